FILE: design/mov_instruction_byte_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MOV byte decoder
// Concurrent check wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MOV_INSTRUCTION_BYTE_DECODER_TOP_MACROS_SVH
`define MOV_INSTRUCTION_BYTE_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define MBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define MBD_ASSERT_NOW(label, clk, rst, ante, cons)
`define MBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/mbd_pkg.sv
// ----------------------------------------------------------------------------
// MOV byte decoder package
// Shared types and opcode constants.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;

   // opcode patterns
   localparam logic [5:0] OPC_RM_REG  = 6'b100010;  // 100010dw
   localparam logic [3:0] OPC_IMM_REG = 4'b1011;    // 1011wreg

   // MOD / R/M codes
   localparam logic [1:0] MOD_MEM_NODISP = 2'd0;
   localparam logic [1:0] MOD_MEM_DISP8  = 2'd1;
   localparam logic [1:0] MOD_MEM_DISP16 = 2'd2;
   localparam logic [1:0] MOD_REGISTER   = 2'd3;
   localparam logic [2:0] RM_DIRECT      = 3'd6;

   // argument byte position
   localparam logic [1:0] IDX_OPCODE = 2'd0;
   localparam logic [1:0] IDX_ARG1   = 2'd1;
   localparam logic [1:0] IDX_ARG2   = 2'd2;
   localparam logic [1:0] IDX_ARG3   = 2'd3;

   // result status / form codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;
   localparam logic FORM_RM_REG  = 1'b0;
   localparam logic FORM_IMM_REG = 1'b1;

   typedef struct packed {
      logic              status;
      logic              form;
      logic              word_op;
      logic              reg_is_dest;
      logic [1:0]        mode;
      logic [2:0]        reg_field;
      logic [2:0]        rm_field;
      logic [WORD_W-1:0] displacement;
      logic [WORD_W-1:0] immediate;
   } result_type;

   // input stage -> core
   typedef struct packed {
      logic              fire;
      logic [BYTE_W-1:0] code_byte;
   } step_type;

   // core -> output stage
   typedef struct packed {
      logic       load;
      result_type data;
   } emit_type;

endpackage

FILE: design/mbd_channels.sv
// ----------------------------------------------------------------------------
// MOV byte decoder channels
// Valid/ready interfaces for the byte stream and the decoded results.
// ----------------------------------------------------------------------------
interface mbd_req_if;
   import mbd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;

   logic              valid;
   logic              ready;
   logic              status;
   logic              form;
   logic              word_op;
   logic              reg_is_dest;
   logic [1:0]        mode;
   logic [2:0]        reg_field;
   logic [2:0]        rm_field;
   logic [WORD_W-1:0] displacement;
   logic [WORD_W-1:0] immediate;

   modport source (output valid, output status, output form, output word_op,
                   output reg_is_dest, output mode, output reg_field,
                   output rm_field, output displacement, output immediate,
                   input ready);
   modport sink   (input valid, input status, input form, input word_op,
                   input reg_is_dest, input mode, input reg_field,
                   input rm_field, input displacement, input immediate,
                   output ready);
endinterface

FILE: design/mov_instruction_byte_decoder_top.sv
// A result reaches rsp_ch through the byte register and then the result register.
// Throughput: one byte per cycle; req_ch.ready stays high while the result register
//   is empty or being drained, so stalls come only from rsp_ch backpressure.
// Reset: synchronous, active high; clears the handshake registers and the decode state
//   (awaiting an opcode, not halted).
// ----------------------------------------------------------------------------
// MOV instruction byte decoder, top level
// Decodes MOV r/m<->reg (100010dw) and MOV imm->reg (1011wreg) from a byte stream.
// ----------------------------------------------------------------------------
module mov_instruction_byte_decoder_top (
   input  logic clock,
   input  logic reset,
   mbd_req_if.sink   req_ch,
   mbd_rsp_if.source rsp_ch
);
   import mbd_pkg::*;

   // Pipeline: byte register -> decode logic -> result register.
   // The decode state (position within the instruction, latched fields,
   // displacement and immediate accumulators) lives in the core and is
   // updated only when the registered byte advances, i.e. when the result
   // register can take whatever that byte produces.
   step_type step;
   emit_type emit;
   logic     can_take;

   // Input register: holds one byte, refilled in the cycle it advances.
   mbd_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .can_take (can_take),
      .step     (step)
   );

   // Decode core: opcode match, ModRM split, displacement/data assembly,
   // error halt. Emits at most one result per byte.
   mbd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .emit  (emit)
   );

   // Result register: parts the decode from rsp_ch so a waiting result
   // does not stop the next byte from being taken.
   mbd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: design/mbd_in_stage.sv
// ----------------------------------------------------------------------------
// MOV byte decoder input stage
// Registers one code byte; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module mbd_in_stage (
   input  logic              clock,
   input  logic              reset,
   mbd_req_if.sink           req_ch,
   input  logic              can_take,
   output mbd_pkg::step_type step
);
   import mbd_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              advance;
   logic              take;

   assign advance      = in_valid_ff && can_take;
   assign req_ch.ready = !in_valid_ff || can_take;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (take) begin
         in_valid_in = 1'b1;
         byte_in     = req_ch.code_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      byte_ff <= byte_in;
   end

   assign step.fire      = advance;
   assign step.code_byte = byte_ff;

endmodule

FILE: design/mbd_core.sv
// ----------------------------------------------------------------------------
// MOV byte decoder core
// Per-byte decode state and result formation for the two MOV forms.
// ----------------------------------------------------------------------------
`include "mov_instruction_byte_decoder_top_macros.svh"

module mbd_core (
   input  logic              clock,
   input  logic              reset,
   input  mbd_pkg::step_type step,
   output mbd_pkg::emit_type emit
);
   import mbd_pkg::*;

   logic              reading_ff, reading_in;
   logic [1:0]        idx_ff, idx_in;
   logic              form_ff, form_in;
   logic              word_ff, word_in;
   logic              dir_ff, dir_in;
   logic [1:0]        mod_ff, mod_in;
   logic [2:0]        reg_ff, reg_in;
   logic [2:0]        rm_ff, rm_in;
   logic [WORD_W-1:0] disp_ff, disp_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              halted_ff, halted_in;
   logic              done;
   logic              bad_opcode;
   logic [BYTE_W-1:0] b;

   assign b = step.code_byte;

   always_comb begin
      reading_in = reading_ff;
      idx_in     = idx_ff;
      form_in    = form_ff;
      word_in    = word_ff;
      dir_in     = dir_ff;
      mod_in     = mod_ff;
      reg_in     = reg_ff;
      rm_in      = rm_ff;
      disp_in    = disp_ff;
      data_in    = data_ff;
      halted_in  = halted_ff;
      done       = 1'b0;
      bad_opcode = 1'b0;

      if (step.fire && !halted_ff) begin
         if (!reading_ff) begin
            if (b[7:2] == OPC_RM_REG) begin
               form_in    = FORM_RM_REG;
               word_in    = b[0];
               dir_in     = b[1];
               reading_in = 1'b1;
               idx_in     = IDX_ARG1;
            end else if (b[7:4] == OPC_IMM_REG) begin
               form_in    = FORM_IMM_REG;
               word_in    = b[3];
               reg_in     = b[2:0];
               reading_in = 1'b1;
               idx_in     = IDX_ARG1;
            end else begin
               bad_opcode = 1'b1;
               halted_in  = 1'b1;
            end
         end else if (form_ff == FORM_RM_REG) begin
            case (idx_ff)
               IDX_ARG1: begin
                  mod_in  = b[7:6];
                  reg_in  = b[5:3];
                  rm_in   = b[2:0];
                  disp_in = '0;
                  if (b[7:6] == MOD_REGISTER ||
                      (b[7:6] == MOD_MEM_NODISP && b[2:0] != RM_DIRECT)) begin
                     done = 1'b1;
                  end else begin
                     idx_in = IDX_ARG2;
                  end
               end
               IDX_ARG2: begin
                  disp_in = {{(WORD_W-BYTE_W){1'b0}}, b};
                  if (mod_ff == MOD_MEM_DISP8) begin
                     done = 1'b1;
                  end else begin
                     idx_in = IDX_ARG3;
                  end
               end
               IDX_ARG3: begin
                  disp_in = {b, disp_ff[BYTE_W-1:0]};
                  done    = 1'b1;
               end
               default: begin
                  reading_in = 1'b0;
                  idx_in     = IDX_OPCODE;
               end
            endcase
         end else begin
            case (idx_ff)
               IDX_ARG1: begin
                  data_in = {{(WORD_W-BYTE_W){1'b0}}, b};
                  if (!word_ff) begin
                     done = 1'b1;
                  end else begin
                     idx_in = IDX_ARG2;
                  end
               end
               IDX_ARG2: begin
                  data_in = {b, data_ff[BYTE_W-1:0]};
                  done    = 1'b1;
               end
               default: begin
                  reading_in = 1'b0;
                  idx_in     = IDX_OPCODE;
               end
            endcase
         end
         if (done) begin
            reading_in = 1'b0;
            idx_in     = IDX_OPCODE;
         end
      end
   end

   // result built from the updated field values
   always_comb begin
      emit.load = done || bad_opcode;
      emit.data = '0;
      if (bad_opcode) begin
         emit.data.status = STATUS_ERROR;
      end else begin
         emit.data.status    = STATUS_OK;
         emit.data.form      = form_in;
         emit.data.word_op   = word_in;
         emit.data.reg_field = reg_in;
         if (form_in == FORM_IMM_REG) begin
            emit.data.reg_is_dest = 1'b1;
            emit.data.immediate   = data_in;
         end else begin
            emit.data.reg_is_dest  = dir_in;
            emit.data.mode         = mod_in;
            emit.data.rm_field     = rm_in;
            emit.data.displacement = disp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= 1'b0;
         idx_ff     <= IDX_OPCODE;
         form_ff    <= 1'b0;
         word_ff    <= 1'b0;
         dir_ff     <= 1'b0;
         mod_ff     <= '0;
         reg_ff     <= '0;
         rm_ff      <= '0;
         disp_ff    <= '0;
         data_ff    <= '0;
         halted_ff  <= 1'b0;
      end else begin
         reading_ff <= reading_in;
         idx_ff     <= idx_in;
         form_ff    <= form_in;
         word_ff    <= word_in;
         dir_ff     <= dir_in;
         mod_ff     <= mod_in;
         reg_ff     <= reg_in;
         rm_ff      <= rm_in;
         disp_ff    <= disp_in;
         data_ff    <= data_in;
         halted_ff  <= halted_in;
      end
   end

   // once halted, nothing more comes out until reset
   `MBD_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff && !emit.load)
   // an error result halts the decoder
   `MBD_ASSERT_NEXT(a_error_halts, clock, reset, bad_opcode, halted_ff)
   // a completed instruction returns to opcode fetch
   `MBD_ASSERT_NEXT(a_done_rearms, clock, reset, done, !reading_ff && idx_ff == IDX_OPCODE)

endmodule

FILE: design/mbd_out_stage.sv
// ----------------------------------------------------------------------------
// MOV byte decoder output stage
// Result register toward the response channel.
// ----------------------------------------------------------------------------
`include "mov_instruction_byte_decoder_top_macros.svh"

module mbd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  mbd_pkg::emit_type emit,
   output logic              can_take,
   mbd_rsp_if.source         rsp_ch
);
   import mbd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // free, or being emptied this cycle
   assign can_take = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.form         = rsp_data_ff.form;
   assign rsp_ch.word_op      = rsp_data_ff.word_op;
   assign rsp_ch.reg_is_dest  = rsp_data_ff.reg_is_dest;
   assign rsp_ch.mode         = rsp_data_ff.mode;
   assign rsp_ch.reg_field    = rsp_data_ff.reg_field;
   assign rsp_ch.rm_field     = rsp_data_ff.rm_field;
   assign rsp_ch.displacement = rsp_data_ff.displacement;
   assign rsp_ch.immediate    = rsp_data_ff.immediate;

   // never overwrite a result that has not been transferred
   `MBD_ASSERT_NOW(a_no_overwrite, clock, reset, emit.load, can_take)

endmodule

FILE: tb/tb_mov_instruction_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// Testbench for the MOV instruction byte decoder
// Streams MOV r/m<->reg and MOV imm->reg encodings into the decoder one byte
// per transfer, and predicts every decoded instruction with a local copy of
// the decode state. Each result is compared field by field. Both channels
// idle and stall at random. A single unknown opcode closes the stream, and
// the bytes after it must be swallowed.
// ----------------------------------------------------------------------------
module tb_mov_instruction_byte_decoder_top;
   import mbd_pkg::*;

   logic clock;
   logic reset;

   mbd_req_if req_if ();
   mbd_rsp_if rsp_if ();

   mov_instruction_byte_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Byte stream still to be sent, and the decoded instructions still owed.
   logic [BYTE_W-1:0] code_stream_q[$];
   result_type        decoded_q[$];

   // Local copy of the decoder state.
   logic              dec_busy;    // opcode seen, argument bytes pending
   logic [1:0]        dec_idx;
   logic              dec_form;
   logic              dec_w;
   logic              dec_d;
   logic [1:0]        dec_mod;
   logic [2:0]        dec_reg;
   logic [2:0]        dec_rm;
   logic [WORD_W-1:0] dec_disp;
   logic [WORD_W-1:0] dec_data;
   logic              dec_halted;

   int fail_count = 0;
   int n_sent     = 0;
   int n_rm_done  = 0;
   int n_imm_done = 0;
   int n_err_done = 0;
   int mod_hits[4] = '{0, 0, 0, 0};

   // idle/stall bookkeeping, one counter per side
   int tx_wait = 0;
   int rx_wait = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Per-item wait: none during a calm stretch, otherwise drawn uniformly at random.
   function automatic int draw_gap(input bit calm);
      if (calm)
         return 0;
      return $urandom_range(0, 12);
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Last byte of an instruction: post its fields and go back to opcode fetch.
   task automatic finish_instr();
      result_type r;
      r           = '0;
      r.status    = STATUS_OK;
      r.form      = dec_form;
      r.word_op   = dec_w;
      r.reg_field = dec_reg;
      if (dec_form == FORM_IMM_REG) begin
         // register is always the destination; no ModRM, no displacement
         r.reg_is_dest = 1'b1;
         r.immediate   = dec_data;
      end else begin
         r.reg_is_dest  = dec_d;
         r.mode         = dec_mod;
         r.rm_field     = dec_rm;
         r.displacement = dec_disp;
      end
      decoded_q.push_back(r);
      dec_busy = 1'b0;
      dec_idx  = IDX_OPCODE;
   endtask

   // Advance the local decoder by one transferred byte.
   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      result_type err;
      err = '0;
      if (dec_halted) begin
         // swallowed until reset
      end else if (!dec_busy) begin
         if (b[7:2] == OPC_RM_REG) begin
            dec_form = FORM_RM_REG;
            dec_w    = b[0];
            dec_d    = b[1];
            dec_busy = 1'b1;
            dec_idx  = IDX_ARG1;
         end else if (b[7:4] == OPC_IMM_REG) begin
            dec_form = FORM_IMM_REG;
            dec_w    = b[3];
            dec_reg  = b[2:0];
            dec_busy = 1'b1;
            dec_idx  = IDX_ARG1;
         end else begin
            err.status = STATUS_ERROR;
            decoded_q.push_back(err);
            dec_halted = 1'b1;
         end
      end else if (dec_form == FORM_RM_REG) begin
         case (dec_idx)
            IDX_ARG1: begin
               dec_mod  = b[7:6];
               dec_reg  = b[5:3];
               dec_rm   = b[2:0];
               dec_disp = '0;
               // register mode, or memory mode without displacement
               if (dec_mod == MOD_REGISTER ||
                   (dec_mod == MOD_MEM_NODISP && dec_rm != RM_DIRECT))
                  finish_instr();
               else
                  dec_idx = IDX_ARG2;
            end
            IDX_ARG2: begin
               dec_disp = {8'h00, b};
               if (dec_mod == MOD_MEM_DISP8)
                  finish_instr();
               else
                  dec_idx = IDX_ARG3;
            end
            IDX_ARG3: begin
               dec_disp[15:8] = b;
               finish_instr();
            end
            default: begin
               dec_busy = 1'b0;
               dec_idx  = IDX_OPCODE;
            end
         endcase
      end else begin
         case (dec_idx)
            IDX_ARG1: begin
               dec_data = {8'h00, b};
               if (!dec_w)
                  finish_instr();
               else
                  dec_idx = IDX_ARG2;
            end
            IDX_ARG2: begin
               dec_data[15:8] = b;
               finish_instr();
            end
            default: begin
               dec_busy = 1'b0;
               dec_idx  = IDX_OPCODE;
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Stream builders
   // ------------------------------------------------------------------------

   // 100010dw, ModRM, then 0/1/2 displacement bytes, low byte first.
   task automatic push_rm(input logic d, input logic w, input logic [1:0] md,
                          input logic [2:0] rg, input logic [2:0] rm,
                          input logic [WORD_W-1:0] disp);
      code_stream_q.push_back({OPC_RM_REG, d, w});
      code_stream_q.push_back({md, rg, rm});
      if (md == MOD_MEM_DISP8) begin
         code_stream_q.push_back(disp[7:0]);
      end else if (md != MOD_REGISTER &&
                   !(md == MOD_MEM_NODISP && rm != RM_DIRECT)) begin
         // 16-bit displacement, or direct address
         code_stream_q.push_back(disp[7:0]);
         code_stream_q.push_back(disp[15:8]);
      end
      mod_hits[md]++;
   endtask

   // 1011wreg, then one data byte, or two for a word.
   task automatic push_imm(input logic w, input logic [2:0] rg,
                           input logic [WORD_W-1:0] data);
      code_stream_q.push_back({OPC_IMM_REG, w, rg});
      code_stream_q.push_back(data[7:0]);
      if (w)
         code_stream_q.push_back(data[15:8]);
   endtask

   // Mostly random 16-bit values, with the ends of the range mixed in.
   function automatic logic [WORD_W-1:0] draw_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return WORD_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Byte driver: one transfer per item, random idle before each send
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      logic held;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.code_byte <= '0;
         tx_wait = draw_gap(tx_calm);
      end else begin
         held = req_if.valid && !req_if.ready;
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.code_byte);
            n_sent++;
         end
         // a byte still waiting for ready keeps valid and data as they are
         if (!held) begin
            if (tx_wait == 0 && code_stream_q.size() != 0) begin
               req_if.valid     <= 1'b1;
               req_if.code_byte <= code_stream_q.pop_front();
               if ($urandom_range(0, 29) == 0)
                  tx_calm = !tx_calm;
               tx_wait = draw_gap(tx_calm);
            end else begin
               req_if.valid <= 1'b0;
               if (tx_wait > 0)
                  tx_wait = tx_wait - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: random backpressure, field-by-field compare
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_wait = draw_gap(rx_calm);
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_q.size() == 0) begin
               $error("result transfer with nothing outstanding");
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_if.status));
               check_field("form", 32'(want.form), 32'(rsp_if.form));
               check_field("word_op", 32'(want.word_op), 32'(rsp_if.word_op));
               check_field("reg_is_dest", 32'(want.reg_is_dest),
                           32'(rsp_if.reg_is_dest));
               check_field("mode", 32'(want.mode), 32'(rsp_if.mode));
               check_field("reg_field", 32'(want.reg_field), 32'(rsp_if.reg_field));
               check_field("rm_field", 32'(want.rm_field), 32'(rsp_if.rm_field));
               check_field("displacement", 32'(want.displacement),
                           32'(rsp_if.displacement));
               check_field("immediate", 32'(want.immediate), 32'(rsp_if.immediate));
               if (want.status == STATUS_ERROR)
                  n_err_done++;
               else if (want.form == FORM_IMM_REG)
                  n_imm_done++;
               else
                  n_rm_done++;
            end
            if ($urandom_range(0, 29) == 0)
               rx_calm = !rx_calm;
            rx_wait = draw_gap(rx_calm);
         end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
         end
         rsp_if.ready <= (rx_wait == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [BYTE_W-1:0] bad_op;
      logic [1:0]        md;
      logic [2:0]        rm;

      // known values on every input from time zero
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.code_byte = '0;
      rsp_if.ready     = 1'b0;

      dec_busy   = 1'b0;
      dec_idx    = IDX_OPCODE;
      dec_form   = FORM_RM_REG;
      dec_w      = 1'b0;
      dec_d      = 1'b0;
      dec_mod    = '0;
      dec_reg    = '0;
      dec_rm     = '0;
      dec_disp   = '0;
      dec_data   = '0;
      dec_halted = 1'b0;

      // directed: field extremes and each addressing case
      push_rm(1'b0, 1'b0, MOD_REGISTER,   3'd0, 3'd0, 16'h0000); // all-zero fields
      push_rm(1'b1, 1'b1, MOD_REGISTER,   3'd7, 3'd7, 16'h0000); // all-ones fields
      push_rm(1'b0, 1'b1, MOD_MEM_NODISP, 3'd5, 3'd3, 16'h0000); // no displacement
      push_rm(1'b1, 1'b0, MOD_MEM_NODISP, 3'd2, RM_DIRECT, 16'hFFFF); // direct address
      push_rm(1'b0, 1'b1, MOD_MEM_DISP8,  3'd1, RM_DIRECT, 16'h00FF); // disp8, no sign ext
      push_rm(1'b1, 1'b1, MOD_MEM_DISP16, 3'd6, 3'd0, 16'h8001); // disp16
      push_imm(1'b0, 3'd0, 16'h0000);
      push_imm(1'b0, 3'd7, 16'h00FF);
      push_imm(1'b1, 3'd3, 16'hFFFF);
      push_imm(1'b1, 3'd4, 16'h0000);

      // random: well-formed instructions with random content
      while (code_stream_q.size() < 650) begin
         if ($urandom_range(0, 1)) begin
            md = 2'($urandom_range(0, 3));
            rm = 3'($urandom_range(0, 7));
            // lean toward the direct-address case in memory mode 0
            if (md == MOD_MEM_NODISP && $urandom_range(0, 3) == 0)
               rm = RM_DIRECT;
            push_rm(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), md,
                    3'($urandom_range(0, 7)), rm, draw_word());
         end else begin
            push_imm(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     draw_word());
         end
      end

      // An unknown opcode halts the decoder until reset, and reset is applied
      // only once, so it closes the stream. Trailing bytes must be ignored.
      do
         bad_op = BYTE_W'($urandom_range(0, 255));
      while (bad_op[7:2] == OPC_RM_REG || bad_op[7:4] == OPC_IMM_REG);
      code_stream_q.push_back(bad_op);
      code_stream_q.push_back({OPC_IMM_REG, 1'b0, 3'd1});
      code_stream_q.push_back({OPC_RM_REG, 2'b11});
      repeat (4)
         code_stream_q.push_back(BYTE_W'($urandom_range(0, 255)));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all bytes sent, then all results drained, then a short quiet tail
      while (code_stream_q.size() != 0 || req_if.valid)
         @(posedge clock);
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Summary: %0d bytes transferred; decoded %0d r/m-reg, %0d imm-reg, %0d error",
               n_sent, n_rm_done, n_imm_done, n_err_done);
      $display("Summary: r/m-reg by MOD field: 0:%0d 1:%0d 2:%0d 3:%0d",
               mod_hits[0], mod_hits[1], mod_hits[2], mod_hits[3]);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
